// ===== hw/rtl/sprite_frame_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sprite frame sequencer
// Implication checks on a clock, with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SPRSEQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sprite frame sequencer check failed");

// next-cycle implication
`define SPRSEQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sprite frame sequencer check failed");

`endif

// ===== hw/rtl/sprseq_pkg.sv =====
// ----------------------------------------------------------------------------
// sprseq_pkg
// Shared field widths, register indexes, reset values and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sprseq_pkg;

  localparam int IMG_W      = 11;
  localparam int FPR_W      = 7;
  localparam int ROWS_W     = 5;
  localparam int PERIOD_W   = 16;
  localparam int TEX_W      = 15;
  localparam int DELTA_W    = 16;
  localparam int SPR_IN_W   = 8;
  localparam int FSEL_W     = 10;
  localparam int LEFT_W     = 24;
  localparam int TOP_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int BOUNCE_BACK = 2;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_SPR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_ENABLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 3'd6;

  localparam logic [IMG_W-1:0]    RST_IMAGE_WIDTH    = 11'd32;
  localparam logic [IMG_W-1:0]    RST_IMAGE_HEIGHT   = 11'd32;
  localparam logic [FPR_W-1:0]    RST_FRAMES_PER_ROW = 7'd4;
  localparam logic [ROWS_W-1:0]   RST_ROWS_PER_SPR   = 5'd1;
  localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD   = 16'd0;
  localparam logic                RST_BOUNCE_ENABLE  = 1'b0;
  localparam logic [TEX_W-1:0]    RST_TEXTURE_HEIGHT = 15'd256;

  typedef struct packed {
    logic [IMG_W-1:0]    image_width;
    logic [IMG_W-1:0]    image_height;
    logic [FPR_W-1:0]    frames_per_row;
    logic [ROWS_W-1:0]   rows_per_sprite;
    logic [PERIOD_W-1:0] frame_period;
    logic                bounce_enable;
    logic [TEX_W-1:0]    texture_height;
  } cfg_t;

  typedef struct packed {
    logic update;     // apply accepted item to sequencer state
    logic div_frame;  // load divider with frame / frames_per_row
    logic div_time;   // load divider with top / texture_height
    logic div_step;   // one restoring-divide step
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic mul_d;
    logic out_load;
  } cmd_t;

  // Width of the sheet-row value (top before folding), one bit of headroom.
  function automatic int div_width(int frame_bits, int sprite_bits);
    int a;
    int b;
    a = IMG_W + sprite_bits + ROWS_W;
    b = IMG_W + frame_bits;
    return ((a > b) ? a : b) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer: sprite-sheet frame sequencer with rectangle origin
// Runs the bit-serial divider twice per item; a new item is taken only once
// the previous one has been loaded into the output register. rst_n (sync)
// resets the configuration, sequencer state and FSM, not the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer
  import sprseq_pkg::*;
#(
  parameter int FRAME_BITS  = 10,
  parameter int TIME_BITS   = 16,
  parameter int SPRITE_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [DELTA_W-1:0]    in_delta_ticks,
  input  wire logic [SPR_IN_W-1:0]   in_sprite_select,
  input  wire logic [FSEL_W-1:0]     in_frame_select,
  input  wire logic                  in_keep_frame,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LEFT_W-1:0]          out_rect_left,
  output logic [TOP_W-1:0]           out_rect_top,
  output logic [FSEL_W-1:0]          out_frame_now,
  output logic                       out_frame_stepped,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;

  sprseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sprseq_ctrl #(
    .FRAME_BITS  (FRAME_BITS),
    .SPRITE_BITS (SPRITE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sprseq_dp #(
    .FRAME_BITS  (FRAME_BITS),
    .TIME_BITS   (TIME_BITS),
    .SPRITE_BITS (SPRITE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg),
    .in_req_type       (in_req_type),
    .in_delta_ticks    (in_delta_ticks),
    .in_sprite_select  (in_sprite_select),
    .in_frame_select   (in_frame_select),
    .in_keep_frame     (in_keep_frame),
    .out_rect_left     (out_rect_left),
    .out_rect_top      (out_rect_top),
    .out_frame_now     (out_frame_now),
    .out_frame_stepped (out_frame_stepped)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sprseq_cfg.sv =====
// ----------------------------------------------------------------------------
// sprseq_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sprseq_cfg
  import sprseq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    cfg_nxt.image_width     = cfg_data[IMG_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_nxt.image_height    = cfg_data[IMG_W-1:0];
        REG_FRAMES_PER_ROW: cfg_nxt.frames_per_row  = cfg_data[FPR_W-1:0];
        REG_ROWS_PER_SPR:   cfg_nxt.rows_per_sprite = cfg_data[ROWS_W-1:0];
        REG_FRAME_PERIOD:   cfg_nxt.frame_period    = cfg_data[PERIOD_W-1:0];
        REG_BOUNCE_ENABLE:  cfg_nxt.bounce_enable   = cfg_data[0];
        REG_TEXTURE_HEIGHT: cfg_nxt.texture_height  = cfg_data[TEX_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= RST_IMAGE_WIDTH;
      cfg_r.image_height    <= RST_IMAGE_HEIGHT;
      cfg_r.frames_per_row  <= RST_FRAMES_PER_ROW;
      cfg_r.rows_per_sprite <= RST_ROWS_PER_SPR;
      cfg_r.frame_period    <= RST_FRAME_PERIOD;
      cfg_r.bounce_enable   <= RST_BOUNCE_ENABLE;
      cfg_r.texture_height  <= RST_TEXTURE_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sprseq_dp.sv =====
// ----------------------------------------------------------------------------
// sprseq_dp
// Sequencer state, shared restoring divider, multiplier steps and result
// register for the sheet rectangle origin.
// ----------------------------------------------------------------------------
`default_nettype none

module sprseq_dp
  import sprseq_pkg::*;
#(
  parameter int FRAME_BITS  = 10,
  parameter int TIME_BITS   = 16,
  parameter int SPRITE_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  input  wire cfg_t                cfg,
  input  wire logic                in_req_type,
  input  wire logic [DELTA_W-1:0]  in_delta_ticks,
  input  wire logic [SPR_IN_W-1:0] in_sprite_select,
  input  wire logic [FSEL_W-1:0]   in_frame_select,
  input  wire logic                in_keep_frame,
  output logic [LEFT_W-1:0]        out_rect_left,
  output logic [TOP_W-1:0]         out_rect_top,
  output logic [FSEL_W-1:0]        out_frame_now,
  output logic                     out_frame_stepped
);

  localparam int AW   = TIME_BITS + 1;
  localparam int CW   = FRAME_BITS + 1;
  localparam int NRW  = FPR_W + ROWS_W;
  localparam int XW   = NRW + CW;
  localparam int M1W  = IMG_W + SPRITE_BITS;
  localparam int T1W  = M1W + ROWS_W;
  localparam int T2W  = IMG_W + FRAME_BITS;
  localparam int DW   = div_width(FRAME_BITS, SPRITE_BITS);
  localparam int RW   = TEX_W + 1;
  localparam int P0W  = IMG_W + FRAME_BITS;
  localparam int P1W  = DW + FPR_W;
  localparam int P2W  = LEFT_W + IMG_W;
  localparam int CMPW = AW + PERIOD_W;

  // sequencer state
  logic [AW-1:0]          acc_r;
  logic [FRAME_BITS-1:0]  frame_r;
  logic [SPRITE_BITS-1:0] sprite_r;
  logic                   rev_r;
  logic                   stepped_r;

  // divider and product registers
  logic [DW-1:0]    quo_r;
  logic [RW-1:0]    rem_r;
  logic [TEX_W-1:0] dvs_r;
  logic [M1W-1:0]   m1_r;
  logic [T1W-1:0]   m2_r;
  logic [T2W-1:0]   m3_r;
  logic [LEFT_W-1:0] p0_r;
  logic [LEFT_W-1:0] p1_r;
  logic [LEFT_W-1:0] p2_r;

  logic [LEFT_W-1:0] rect_left_r;
  logic [TOP_W-1:0]  rect_top_r;
  logic [FSEL_W-1:0] frame_now_r;
  logic              frame_stepped_r;

  // geometry with zero fields treated as one
  logic [FPR_W-1:0]  fpr_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic [TEX_W-1:0]  th_eff;
  logic              rows_gt1;
  logic [NRW-1:0]    n_raw;
  logic [XW-1:0]     n_cap;
  logic [CW-1:0]     n;
  logic [FRAME_BITS-1:0] n_last;
  logic [FRAME_BITS-1:0] bounce_hi;
  logic [FRAME_BITS-1:0] bounce_lo;

  assign fpr_eff  = (cfg.frames_per_row == '0) ? FPR_W'(1) : cfg.frames_per_row;
  assign rows_eff = (cfg.rows_per_sprite == '0) ? ROWS_W'(1) : cfg.rows_per_sprite;
  assign th_eff   = (cfg.texture_height == '0) ? TEX_W'(1) : cfg.texture_height;
  assign rows_gt1 = (rows_eff > ROWS_W'(1));
  assign n_raw    = NRW'(fpr_eff) * NRW'(rows_eff);
  assign n_cap    = XW'(1) << FRAME_BITS;
  assign n        = (XW'(n_raw) > n_cap) ? CW'(n_cap) : CW'(n_raw);
  assign n_last   = FRAME_BITS'(n - CW'(1));
  assign bounce_hi = (n >= CW'(BOUNCE_BACK)) ? FRAME_BITS'(n - CW'(BOUNCE_BACK)) : '0;
  assign bounce_lo = (n >= CW'(BOUNCE_BACK)) ? FRAME_BITS'(1) : '0;

  // frame step
  logic [CW-1:0]         f_inc;
  logic [CW-1:0]         f_dec;
  logic [FRAME_BITS-1:0] adv_frame;
  logic                  adv_rev;

  always_comb begin
    f_inc     = CW'(frame_r) + CW'(1);
    f_dec     = CW'(frame_r) - CW'(1);
    adv_frame = frame_r;
    adv_rev   = rev_r;
    if (rev_r) begin
      if (frame_r == '0) begin
        if (cfg.bounce_enable) begin
          adv_rev   = 1'b0;
          adv_frame = bounce_lo;
        end else begin
          adv_frame = n_last;
        end
      end else if (f_dec >= n) begin
        // frame was set beyond the count
        if (cfg.bounce_enable) begin
          adv_rev   = 1'b1;
          adv_frame = bounce_hi;
        end else begin
          adv_frame = '0;
        end
      end else begin
        adv_frame = FRAME_BITS'(f_dec);
      end
    end else if (f_inc >= n) begin
      if (cfg.bounce_enable) begin
        adv_rev   = 1'b1;
        adv_frame = bounce_hi;
      end else begin
        adv_frame = '0;
      end
    end else begin
      adv_frame = FRAME_BITS'(f_inc);
    end
  end

  // saturating time accumulator
  logic [TIME_BITS-1:0] delta;
  logic [AW:0]          acc_sum;
  logic [AW-1:0]        acc_sat;
  logic                 period_hit;

  assign delta      = TIME_BITS'(in_delta_ticks);
  assign acc_sum    = (AW+1)'(acc_r) + (AW+1)'(delta);
  assign acc_sat    = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
  assign period_hit = (cfg.frame_period != '0) &&
                      (CMPW'(acc_sat) >= CMPW'(cfg.frame_period));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      frame_r   <= '0;
      sprite_r  <= '0;
      rev_r     <= 1'b0;
      stepped_r <= 1'b0;
    end else if (cmd.update) begin
      if (in_req_type == REQ_TICK) begin
        stepped_r <= period_hit;
        if (period_hit) begin
          acc_r   <= '0;
          frame_r <= adv_frame;
          rev_r   <= adv_rev;
        end else begin
          acc_r <= acc_sat;
        end
      end else begin
        stepped_r <= 1'b0;
        sprite_r  <= SPRITE_BITS'(in_sprite_select);
        if (!in_keep_frame) begin
          frame_r <= FRAME_BITS'(in_frame_select);
        end
      end
    end
  end

  // restoring divider, one quotient bit per step; dividend enters at the top
  logic [RW-1:0] rem_sh;
  logic          div_ge;

  assign rem_sh = {rem_r[RW-2:0], quo_r[DW-1]};
  assign div_ge = (rem_sh >= RW'(dvs_r));

  // first divide yields row within sprite (quotient) and column (remainder)
  logic [FRAME_BITS-1:0] q_row;
  logic [FRAME_BITS-1:0] r_col;
  logic [P0W-1:0]        p0_full;
  logic [P1W-1:0]        p1_full;
  logic [P2W-1:0]        p2_full;

  assign q_row   = FRAME_BITS'(quo_r);
  assign r_col   = rows_gt1 ? FRAME_BITS'(rem_r) : frame_r;
  assign p0_full = P0W'(cfg.image_width) * P0W'(r_col);
  assign p1_full = P1W'(quo_r) * P1W'(fpr_eff);
  assign p2_full = P2W'(p1_r) * P2W'(cfg.image_width);

  always_ff @(posedge clk) begin
    if (cmd.div_frame) begin
      dvs_r <= TEX_W'(fpr_eff);
      rem_r <= '0;
      quo_r <= {frame_r, {(DW-FRAME_BITS){1'b0}}};
    end else if (cmd.div_time) begin
      dvs_r <= th_eff;
      rem_r <= '0;
      quo_r <= DW'(m2_r) + DW'(m3_r);
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? (rem_sh - RW'(dvs_r)) : rem_sh;
      quo_r <= {quo_r[DW-2:0], div_ge};
    end
    if (cmd.mul_a) begin
      m1_r <= M1W'(cfg.image_height) * M1W'(sprite_r);
      m3_r <= rows_gt1 ? (T2W'(cfg.image_height) * T2W'(q_row)) : '0;
      p0_r <= LEFT_W'(p0_full);
    end
    if (cmd.mul_b) begin
      m2_r <= T1W'(m1_r) * T1W'(rows_eff);
    end
    if (cmd.mul_c) begin
      p1_r <= LEFT_W'(p1_full);
    end
    if (cmd.mul_d) begin
      p2_r <= LEFT_W'(p2_full);
    end
    if (cmd.out_load) begin
      rect_left_r     <= p0_r + p2_r;
      rect_top_r      <= TOP_W'(rem_r);
      frame_now_r     <= FSEL_W'(frame_r);
      frame_stepped_r <= stepped_r;
    end
  end

  assign out_rect_left     = rect_left_r;
  assign out_rect_top      = rect_top_r;
  assign out_frame_now     = frame_now_r;
  assign out_frame_stepped = frame_stepped_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sprseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sprseq_ctrl
// Sequencing FSM: accepts an item, walks the divide and multiply steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_frame_sequencer_assert.svh"

module sprseq_ctrl
  import sprseq_pkg::*;
#(
  parameter int FRAME_BITS  = 10,
  parameter int SPRITE_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  localparam int DW    = div_width(FRAME_BITS, SPRITE_BITS);
  localparam int CNT_W = $clog2(DW + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV1_INIT = 4'd1;
  localparam logic [3:0] S_DIV1      = 4'd2;
  localparam logic [3:0] S_MUL_A     = 4'd3;
  localparam logic [3:0] S_MUL_B     = 4'd4;
  localparam logic [3:0] S_DIV2_INIT = 4'd5;
  localparam logic [3:0] S_DIV2      = 4'd6;
  localparam logic [3:0] S_MUL_C     = 4'd7;
  localparam logic [3:0] S_MUL_D     = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.update = 1'b1;
          state_nxt  = S_DIV1_INIT;
        end
      end
      S_DIV1_INIT: begin
        cmd.div_frame = 1'b1;
        cnt_nxt       = CNT_W'(FRAME_BITS);
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_DIV2_INIT;
      end
      S_DIV2_INIT: begin
        cmd.div_time = 1'b1;
        cnt_nxt      = CNT_W'(DW);
        state_nxt    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous result is still held
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SPRSEQ_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_DIV1_INIT)
  `SPRSEQ_ASSERT_IMP(a_result_from_out, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_OUT)
  `SPRSEQ_ASSERT_IMP(a_div_count_live, clk, rst_n, state_r == S_DIV1 || state_r == S_DIV2, cnt_r != '0)
  `SPRSEQ_ASSERT_NXT(a_out_stall_holds, clk, rst_n, state_r == S_OUT && out_valid_r && !out_ready, state_r == S_OUT)

endmodule

`default_nettype wire
